>>> src/spptm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spptm_pkg
// Types and constants shared by the page-map permission block.
// ----------------------------------------------------------------------------
package spptm_pkg;

	localparam int ENT         = 1024;
	localparam int ENT_W       = $clog2(ENT);
	localparam int PAGE_W      = 21;            // page number incl. the 4 GiB end mark
	localparam int POOL_TABLES = 8;
	localparam int POOL_W      = $clog2(POOL_TABLES);
	localparam int SLOT_W      = $clog2(POOL_TABLES + 1);
	localparam int TBL_AW      = SLOT_W + ENT_W;
	localparam int TBL_DEPTH   = (POOL_TABLES + 1) * ENT;
	localparam int OWN_W       = 11;

	localparam logic [1:0] FN_SET   = 2'd0;
	localparam logic [1:0] FN_CHECK = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;

	localparam logic [ENT_W-1:0] UC_ENTRY = ENT_W'(32'hFEC00000 >> 22);
	localparam logic [ENT_W-1:0] ENT_MAX  = ENT_W'(ENT - 1);

	typedef struct packed {
		logic lpage;
		logic cd;
		logic wt;
		logic u;
		logic w;
		logic p;
	} dflags_t;

	typedef struct packed {
		logic cd;
		logic wt;
		logic u;
		logic w;
		logic p;
	} tflags_t;

	typedef struct packed {
		logic re;
		logic we;
		logic [ENT_W-1:0] addr;
		dflags_t wdata;
	} dir_req_t;

	typedef struct packed {
		logic re;
		logic we;
		logic [TBL_AW-1:0] addr;
		tflags_t wdata;
	} tbl_req_t;

	typedef struct packed {
		logic is_large;
		logic is_uncached;
		logic is_write_through;
		logic is_writable;
		logic is_user;
		logic is_present;
		logic ok;
	} result_t;

	localparam dflags_t DIR_RST  = '{lpage: 1'b1, cd: 1'b0, wt: 1'b0, u: 1'b0, w: 1'b1, p: 1'b1};
	localparam dflags_t DIR0_RST = '{lpage: 1'b0, cd: 1'b0, wt: 1'b0, u: 1'b0, w: 1'b1, p: 1'b1};
	localparam dflags_t DIRUC_RST = '{lpage: 1'b1, cd: 1'b1, wt: 1'b1, u: 1'b0, w: 1'b1, p: 1'b1};
	localparam tflags_t LOW_RST  = '{cd: 1'b0, wt: 1'b0, u: 1'b0, w: 1'b1, p: 1'b1};

endpackage
`default_nettype wire

>>> src/spptm_dir_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spptm_dir_mem
// Directory flag store, one entry per 4 MiB region, registered read.
// ----------------------------------------------------------------------------
module spptm_dir_mem import spptm_pkg::*; (
	input  wire logic     clk,
	input  wire dir_req_t req,
	output dflags_t       rdata
);

	dflags_t mem [ENT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule
`default_nettype wire

>>> src/spptm_tbl_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spptm_tbl_mem
// Second-level tables: slot 0 is the low table, slots above it the pool.
// ----------------------------------------------------------------------------
module spptm_tbl_mem import spptm_pkg::*; (
	input  wire logic     clk,
	input  wire tbl_req_t req,
	output tflags_t       rdata
);

	tflags_t mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule
`default_nettype wire

>>> src/spptm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spptm_seq
// Page walker: reads directory and table entries, splits, writes back.
// ----------------------------------------------------------------------------
module spptm_seq import spptm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	input  wire logic        want_present,
	input  wire logic        want_user,
	input  wire logic        want_writable,
	input  wire logic        need_write,
	output logic             out_valid,
	input  wire logic        out_ready,
	output result_t          out_data,
	output dir_req_t         dir_req,
	input  wire dflags_t     dir_rdata,
	output tbl_req_t         tbl_req,
	input  wire tflags_t     tbl_rdata
);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_RD_DIR = 9'b000000100,
		ST_EV_DIR = 9'b000001000,
		ST_FILL   = 9'b000010000,
		ST_RD_TBL = 9'b000100000,
		ST_EV_TBL = 9'b001000000,
		ST_RESP   = 9'b010000000,
		ST_SPARE  = 9'b100000000
	} state_t;

	state_t               state_q, state_d;
	logic [1:0]           func_q, func_d;
	logic [PAGE_W-1:0]    page_q, page_d, last_q, last_d;
	logic                 fp_q, fu_q, fw_q, nw_q, fp_d, fu_d, fw_d, nw_d;
	logic [SLOT_W-1:0]    slot_q, slot_d;
	dflags_t              dcur_q, dcur_d;
	tflags_t              fill_q, fill_d;
	logic [ENT_W-1:0]     cnt_q, cnt_d;
	logic [OWN_W-1:0]     owner_q [POOL_TABLES];
	logic                 own_we;
	logic [SLOT_W-1:0]    own_slot;
	logic                 en_q;
	result_t              res_q, res_d, out_q, out_d;
	logic                 outv_q, outv_d;

	logic [32:0]          sum33, e33;
	logic [ENT_W-1:0]     idx;
	logic [OWN_W-1:0]     tag;
	logic                 hit, has_free, tbl_ok, found_ok;
	logic [SLOT_W-1:0]    hit_slot, free_slot, found_slot;
	logic [PAGE_W-1:0]    page_inc, page_big;
	logic                 eval_go, eval_lg;
	tflags_t              eval_f;

	assign idx = page_q[ENT_W+ENT_W-1:ENT_W];
	assign tag = OWN_W'(idx) + OWN_W'(1);
	assign sum33 = {1'b0, address} + {1'b0, length};
	assign e33 = sum33 - 33'd1;
	assign page_inc = page_q + PAGE_W'(1);
	assign page_big = page_q + PAGE_W'(ENT);

	// owner search over the pool slots
	always_comb begin
		hit = 1'b0;
		has_free = 1'b0;
		hit_slot = '0;
		free_slot = '0;
		for (int s = POOL_TABLES - 1; s >= 0; s--) begin
			if (owner_q[s] == tag) begin
				hit = 1'b1;
				hit_slot = SLOT_W'(s + 1);
			end
			if (owner_q[s] == '0) begin
				has_free = 1'b1;
				free_slot = SLOT_W'(s + 1);
			end
		end
	end

	assign tbl_ok = dir_rdata.p & ~dir_rdata.lpage;
	assign found_ok = tbl_ok & ((idx == '0) | hit);
	assign found_slot = (idx == '0) ? '0 : hit_slot;

	always_comb begin
		state_d = state_q;
		func_d = func_q;
		page_d = page_q;
		last_d = last_q;
		fp_d = fp_q;
		fu_d = fu_q;
		fw_d = fw_q;
		nw_d = nw_q;
		slot_d = slot_q;
		dcur_d = dcur_q;
		fill_d = fill_q;
		cnt_d = cnt_q;
		res_d = res_q;
		out_d = out_q;
		outv_d = outv_q;
		own_we = 1'b0;
		own_slot = free_slot;
		dir_req = '0;
		tbl_req = '0;
		eval_go = 1'b0;
		eval_lg = 1'b0;
		eval_f = '0;
		if (out_ready) begin
			outv_d = 1'b0;
		end
		unique case (state_q)
			ST_CLEAR: begin
				dir_req.we = 1'b1;
				dir_req.addr = cnt_q;
				dir_req.wdata = (cnt_q == '0) ? DIR0_RST :
					(cnt_q == UC_ENTRY) ? DIRUC_RST : DIR_RST;
				tbl_req.we = 1'b1;
				tbl_req.addr = TBL_AW'(cnt_q);
				tbl_req.wdata = (cnt_q == '0) ? tflags_t'('0) : LOW_RST;
				cnt_d = cnt_q + ENT_W'(1);
				if (cnt_q == ENT_MAX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					func_d = func;
					fp_d = want_present;
					fu_d = want_user;
					fw_d = want_writable;
					// a zero-length check only asks for a user page
					nw_d = need_write & (length != '0);
					page_d = {1'b0, address[31:12]};
					res_d = '0;
					state_d = ST_RESP;
					priority if (func == FN_SET) begin
						last_d = {1'b0, sum33[31:12]} + PAGE_W'(|sum33[11:0]);
						if (en_q && length != '0 && !sum33[32]) begin
							state_d = ST_RD_DIR;
						end
					end else if (func == FN_CHECK) begin
						last_d = (length == '0) ? {1'b0, address[31:12]} : {1'b0, e33[31:12]};
						if (address == '0) begin
							res_d.ok = (length == '0);
						end else if (length == '0 || !e33[32]) begin
							state_d = ST_RD_DIR;
						end
					end else if (func == FN_QUERY) begin
						state_d = ST_RD_DIR;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_RD_DIR: begin
				dir_req.re = 1'b1;
				dir_req.addr = idx;
				state_d = ST_EV_DIR;
			end
			ST_EV_DIR: begin
				dcur_d = dir_rdata;
				if (func_q == FN_SET) begin
					if (dir_rdata.lpage && page_q[ENT_W-1:0] == '0 &&
						(last_q - page_q) >= PAGE_W'(ENT)) begin
						dir_req.we = 1'b1;
						dir_req.addr = idx;
						dir_req.wdata = '{lpage: 1'b1, cd: dir_rdata.cd, wt: dir_rdata.wt,
							u: fu_q, w: fw_q, p: fp_q};
						page_d = page_big;
						if (page_big >= last_q) begin
							res_d.ok = 1'b1;
							state_d = ST_RESP;
						end else begin
							state_d = ST_RD_DIR;
						end
					end else if (found_ok) begin
						slot_d = found_slot;
						state_d = ST_RD_TBL;
					end else if (tbl_ok) begin
						state_d = ST_RESP;
					end else if (hit) begin
						slot_d = hit_slot;
						state_d = ST_RD_TBL;
					end else if (has_free) begin
						// split: claim a pool table and fill it from the large entry
						own_we = 1'b1;
						slot_d = free_slot;
						fill_d = '{cd: dir_rdata.cd, wt: dir_rdata.wt, u: dir_rdata.u,
							w: dir_rdata.w, p: 1'b1};
						dcur_d = '{lpage: 1'b0, cd: 1'b0, wt: 1'b0, u: dir_rdata.u,
							w: 1'b1, p: 1'b1};
						dir_req.we = 1'b1;
						dir_req.addr = idx;
						dir_req.wdata = dcur_d;
						cnt_d = '0;
						state_d = ST_FILL;
					end else begin
						state_d = ST_RESP;
					end
				end else begin
					if (dir_rdata.p && dir_rdata.lpage) begin
						eval_go = 1'b1;
						eval_lg = 1'b1;
						eval_f = '{cd: dir_rdata.cd, wt: dir_rdata.wt, u: dir_rdata.u,
							w: dir_rdata.w, p: 1'b1};
					end else if (found_ok) begin
						slot_d = found_slot;
						state_d = ST_RD_TBL;
					end else begin
						eval_go = 1'b1;
					end
				end
			end
			ST_FILL: begin
				tbl_req.we = 1'b1;
				tbl_req.addr = {slot_q, cnt_q};
				tbl_req.wdata = fill_q;
				cnt_d = cnt_q + ENT_W'(1);
				if (cnt_q == ENT_MAX) begin
					state_d = ST_RD_TBL;
				end
			end
			ST_RD_TBL: begin
				tbl_req.re = 1'b1;
				tbl_req.addr = {slot_q, page_q[ENT_W-1:0]};
				state_d = ST_EV_TBL;
			end
			ST_EV_TBL: begin
				if (func_q == FN_SET) begin
					tbl_req.we = 1'b1;
					tbl_req.addr = {slot_q, page_q[ENT_W-1:0]};
					tbl_req.wdata = '{cd: tbl_rdata.cd, wt: tbl_rdata.wt,
						u: fu_q, w: fw_q, p: fp_q};
					if (fu_q) begin
						dir_req.we = 1'b1;
						dir_req.addr = idx;
						dir_req.wdata = dcur_q;
						dir_req.wdata.u = 1'b1;
					end
					page_d = page_inc;
					if (page_inc >= last_q) begin
						res_d.ok = 1'b1;
						state_d = ST_RESP;
					end else begin
						state_d = ST_RD_DIR;
					end
				end else begin
					eval_go = 1'b1;
					eval_f = tbl_rdata;
				end
			end
			ST_RESP: begin
				if (!outv_q || out_ready) begin
					outv_d = 1'b1;
					out_d = res_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// verdict on one looked-up page for check and query
		if (eval_go) begin
			res_d = '0;
			if (func_q == FN_QUERY) begin
				res_d.ok = eval_f.p & eval_f.u;
				res_d.is_present = eval_f.p;
				res_d.is_user = eval_f.u;
				res_d.is_writable = eval_f.w;
				res_d.is_write_through = eval_f.wt;
				res_d.is_uncached = eval_f.cd;
				res_d.is_large = eval_lg;
				state_d = ST_RESP;
			end else if (!(eval_f.p && eval_f.u && (!nw_q || eval_f.w))) begin
				state_d = ST_RESP;
			end else if (page_q >= last_q) begin
				res_d.ok = 1'b1;
				state_d = ST_RESP;
			end else begin
				page_d = page_inc;
				state_d = ST_RD_DIR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			outv_q <= 1'b0;
			en_q <= 1'b1;
			for (int s = 0; s < POOL_TABLES; s++) begin
				owner_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			outv_q <= outv_d;
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (own_we) begin
				owner_q[POOL_W'(own_slot - SLOT_W'(1))] <= tag;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		page_q <= page_d;
		last_q <= last_d;
		fp_q <= fp_d;
		fu_q <= fu_d;
		fw_q <= fw_d;
		nw_q <= nw_d;
		slot_q <= slot_d;
		dcur_q <= dcur_d;
		fill_q <= fill_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = outv_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

>>> src/split_page_table_permission_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// split_page_table_permission_map
// Access-flag map of an identity-mapped two-level page map with 4 MiB pages.
// ----------------------------------------------------------------------------
// After reset the block loads the directory and low table before it raises
// s_tready; configuration writes are taken during that time. One transaction
// is worked on at a time and its result sits in an output register, so the
// next transaction may be taken while the result waits.
// The directory and table memories each have a registered read. A query reads
// the directory entry and, for a page in a table, the table entry; a check reads
// every page of its range, and a set rewrites whole large entries where it can,
// writes each page in a table and fills each table that it splits off.
// ----------------------------------------------------------------------------
module split_page_table_permission_map import spptm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,     // map_enabled
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// func[1:0], address[33:2], length[65:34], want_present[66], want_user[67],
	// want_writable[68], need_write[69], zero pad
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// ok[0], is_present[1], is_user[2], is_writable[3], is_write_through[4],
	// is_uncached[5], is_large[6], zero pad
	output logic [7:0]       m_tdata
);

	dir_req_t dir_req;
	tbl_req_t tbl_req;
	dflags_t  dir_rdata;
	tflags_t  tbl_rdata;
	result_t  res;

	spptm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.func          (s_tdata[1:0]),
		.address       (s_tdata[33:2]),
		.length        (s_tdata[65:34]),
		.want_present  (s_tdata[66]),
		.want_user     (s_tdata[67]),
		.want_writable (s_tdata[68]),
		.need_write    (s_tdata[69]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_data      (res),
		.dir_req       (dir_req),
		.dir_rdata     (dir_rdata),
		.tbl_req       (tbl_req),
		.tbl_rdata     (tbl_rdata)
	);

	spptm_dir_mem u_dir (
		.clk   (clk),
		.req   (dir_req),
		.rdata (dir_rdata)
	);

	spptm_tbl_mem u_tbl (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

	assign m_tdata = {1'b0, res};

endmodule
`default_nettype wire

>>> src/spptm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spptm_checker
// Port-level checks on the permission map, bound to the top level.
// ----------------------------------------------------------------------------
module spptm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	a_large: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[1])
		else $error("large page reported absent");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] && m_tdata[2] |-> m_tdata[0])
		else $error("present user page without ok");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("pad bit set");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid}))
		else $error("handshake output unknown");

endmodule

bind split_page_table_permission_map spptm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
